// ===== design/tlqe_pkg.sv =====
// Shared types and constants for the thick line quad expander.
`default_nettype none

package tlqe_pkg;

   localparam int COORD_W   = 16;
   localparam int VIEW_W    = 13;
   localparam int THICK_W   = 12;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_VIEW_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_VIEW_HEIGHT = 1'b1;

   localparam logic [VIEW_W-1:0] VIEW_WIDTH_RESET  = 13'd1344;
   localparam logic [VIEW_W-1:0] VIEW_HEIGHT_RESET = 13'd1600;

   localparam int MAG_W      = 29;
   localparam int NORM_MSB   = 28;
   localparam int SHIFT_W    = 5;
   localparam int SQ_W       = 60;
   localparam int ROOT_W     = 30;
   localparam int REM_W      = 33;
   localparam int SQRT_STEPS = 30;
   localparam int NUM_W      = 41;
   localparam int DEN_W      = 43;
   localparam int DIVR_W     = 53;
   localparam int DIVD_W     = 44;
   localparam int DIV_STEPS  = 18;
   localparam int DIVC_W     = 62;
   localparam int OFF_W      = 18;
   localparam int DEGEN_LIMIT = 10;

   // input register, four setup stages, root stages, product stage, divide stages, output
   localparam int LATENCY = 5 + SQRT_STEPS + 1 + DIV_STEPS + 1;

   typedef struct packed {
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
      logic        [THICK_W-1:0] thickness;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] corner0_x;
      logic signed [COORD_W-1:0] corner0_y;
      logic signed [COORD_W-1:0] corner1_x;
      logic signed [COORD_W-1:0] corner1_y;
      logic signed [COORD_W-1:0] corner2_x;
      logic signed [COORD_W-1:0] corner2_y;
      logic signed [COORD_W-1:0] corner3_x;
      logic signed [COORD_W-1:0] corner3_y;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x0;
      logic signed [COORD_W-1:0] y0;
      logic signed [COORD_W-1:0] x1;
      logic signed [COORD_W-1:0] y1;
      logic                      nx;
      logic                      ny;
   } carry_type;

endpackage

`default_nettype wire

// ===== design/thick_line_quad_expand.sv =====
// Top level of the thick line quad expander: pipelined segment to quad corners.
//
// Usage: raise start with a segment on req_payload; it is taken at any edge
// where busy is low. busy is high only during reset and the cycle after it;
// otherwise a new segment may be taken in every cycle.
// Each segment yields one quad on rsp_payload, marked by rsp_strobe for one
// cycle (one result per cycle sustained). The square root has 30 stages (one
// root bit per stage) and the restoring divider has 18 stages (one quotient
// bit per stage per axis).
// The receiver cannot stall; results are never held.
// csr_write_en with csr_index writes the viewport width (0) or height (1);
// write only while no segment is in flight. A zero value acts as one.
// Reset clears all stage valid bits and reloads the viewport registers
// with 1344 by 1600; segments in flight are dropped.
`default_nettype none

module thick_line_quad_expand (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output      logic                                 busy,
   input  wire tlqe_pkg::req_type                    req_payload,
   input  wire logic                                 csr_write_en,
   input  wire logic [tlqe_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [tlqe_pkg::VIEW_W-1:0]          csr_wdata,
   output      logic                                 rsp_strobe,
   output      tlqe_pkg::rsp_type                    rsp_payload
);

   localparam int COORD_W    = tlqe_pkg::COORD_W;
   localparam int VIEW_W     = tlqe_pkg::VIEW_W;
   localparam int THICK_W    = tlqe_pkg::THICK_W;
   localparam int MAG_W      = tlqe_pkg::MAG_W;
   localparam int SHIFT_W    = tlqe_pkg::SHIFT_W;
   localparam int SQ_W       = tlqe_pkg::SQ_W;
   localparam int ROOT_W     = tlqe_pkg::ROOT_W;
   localparam int REM_W      = tlqe_pkg::REM_W;
   localparam int SQRT_STEPS = tlqe_pkg::SQRT_STEPS;
   localparam int NUM_W      = tlqe_pkg::NUM_W;
   localparam int DEN_W      = tlqe_pkg::DEN_W;
   localparam int DIVR_W     = tlqe_pkg::DIVR_W;
   localparam int DIVD_W     = tlqe_pkg::DIVD_W;
   localparam int DIV_STEPS  = tlqe_pkg::DIV_STEPS;
   localparam int DIVC_W     = tlqe_pkg::DIVC_W;
   localparam int OFF_W      = tlqe_pkg::OFF_W;

   function automatic logic [SHIFT_W-1:0] lead_shift(input logic [MAG_W-1:0] v);
      logic [SHIFT_W-1:0] k;
      k = '0;
      for (int i = 0; i < MAG_W; i++) begin
         if (v[i]) begin
            k = SHIFT_W'(tlqe_pkg::NORM_MSB - i);
         end
      end
      return k;
   endfunction

   function automatic logic signed [COORD_W-1:0] sat_coord(
      input logic signed [COORD_W+2:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > (COORD_W+3)'(signed'(32767))) begin
         r = {1'b0, {(COORD_W-1){1'b1}}};
      end else if (v < -(COORD_W+3)'(signed'(32768))) begin
         r = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

   // configuration and handshake
   logic              busy_ff;
   logic [VIEW_W-1:0] view_w_ff, view_h_ff;
   logic [VIEW_W-1:0] w_eff, h_eff;
   logic              accept;

   always_ff @(posedge clock) begin
      busy_ff <= reset;
      if (reset) begin
         view_w_ff <= tlqe_pkg::VIEW_WIDTH_RESET;
         view_h_ff <= tlqe_pkg::VIEW_HEIGHT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            tlqe_pkg::CSR_VIEW_WIDTH:  view_w_ff <= csr_wdata;
            tlqe_pkg::CSR_VIEW_HEIGHT: view_h_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy   = reset | busy_ff;
   assign accept = start & ~busy;
   assign w_eff  = (view_w_ff == '0) ? VIEW_W'(1) : view_w_ff;
   assign h_eff  = (view_h_ff == '0) ? VIEW_W'(1) : view_h_ff;

   // stage 0: differences
   logic                      s0_v_ff;
   tlqe_pkg::carry_type       s0_c_ff;
   logic [THICK_W-1:0]        s0_t_ff;
   logic [COORD_W-1:0]        s0_ax_ff, s0_ay_ff;
   logic signed [COORD_W:0]   dx, dy;

   assign dx = COORD_W'(0) + ((COORD_W+1)'(req_payload.end_x)
             - (COORD_W+1)'(req_payload.start_x));
   assign dy = (COORD_W+1)'(req_payload.end_y) - (COORD_W+1)'(req_payload.start_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
      end else begin
         s0_v_ff <= accept;
      end
      s0_c_ff  <= '{x0: req_payload.start_x, y0: req_payload.start_y,
                    x1: req_payload.end_x,   y1: req_payload.end_y,
                    nx: dx[COORD_W],         ny: dy[COORD_W]};
      s0_t_ff  <= req_payload.thickness;
      s0_ax_ff <= dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
      s0_ay_ff <= dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
   end

   // stage 1: pixel direction
   logic                s1_v_ff;
   tlqe_pkg::carry_type s1_c_ff;
   logic [THICK_W-1:0]  s1_t_ff;
   logic [MAG_W-1:0]    s1_mx_ff, s1_my_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s0_v_ff;
      end
      s1_c_ff  <= s0_c_ff;
      s1_t_ff  <= s0_t_ff;
      s1_mx_ff <= MAG_W'(s0_ax_ff) * MAG_W'(w_eff);
      s1_my_ff <= MAG_W'(s0_ay_ff) * MAG_W'(h_eff);
   end

   // stage 2: squares
   logic                  s2_v_ff;
   tlqe_pkg::carry_type   s2_c_ff;
   logic [THICK_W-1:0]    s2_t_ff;
   logic [MAG_W-1:0]      s2_mx_ff, s2_my_ff;
   logic [2*MAG_W-1:0]    s2_sqx_ff, s2_sqy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else begin
         s2_v_ff <= s1_v_ff;
      end
      s2_c_ff   <= s1_c_ff;
      s2_t_ff   <= s1_t_ff;
      s2_mx_ff  <= s1_mx_ff;
      s2_my_ff  <= s1_my_ff;
      s2_sqx_ff <= (2*MAG_W)'(s1_mx_ff) * (2*MAG_W)'(s1_mx_ff);
      s2_sqy_ff <= (2*MAG_W)'(s1_my_ff) * (2*MAG_W)'(s1_my_ff);
   end

   // stage 3: squared length, normalising shift
   logic                  s3_v_ff;
   tlqe_pkg::carry_type   s3_c_ff;
   logic [THICK_W-1:0]    s3_t_ff;
   logic [MAG_W-1:0]      s3_mx_ff, s3_my_ff;
   logic [SQ_W-1:0]       s3_s_ff;
   logic [SHIFT_W-1:0]    s3_k_ff;
   logic [SQ_W-1:0]       s2_sum;

   assign s2_sum = SQ_W'(s2_sqx_ff) + SQ_W'(s2_sqy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else begin
         s3_v_ff <= s2_v_ff;
      end
      s3_c_ff  <= s2_c_ff;
      s3_t_ff  <= s2_t_ff;
      s3_mx_ff <= s2_mx_ff;
      s3_my_ff <= s2_my_ff;
      s3_s_ff  <= s2_sum;
      s3_k_ff  <= lead_shift(s2_mx_ff | s2_my_ff);
   end

   // stage 4: degenerate test, apply shift or substitute the unit direction
   logic                  s4_v_ff;
   tlqe_pkg::carry_type   s4_c_ff;
   tlqe_pkg::carry_type   s4_c_in;
   logic [THICK_W-1:0]    s4_t_ff;
   logic [MAG_W-1:0]      s4_mx_ff, s4_my_ff;
   logic [SQ_W-1:0]       s4_s_ff;
   logic                  degen;

   assign degen = (s3_s_ff <= SQ_W'(tlqe_pkg::DEGEN_LIMIT));

   always_comb begin
      s4_c_in = s3_c_ff;
      if (degen) begin
         s4_c_in.nx = 1'b0;
         s4_c_in.ny = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else begin
         s4_v_ff <= s3_v_ff;
      end
      s4_c_ff <= s4_c_in;
      s4_t_ff <= s3_t_ff;
      if (degen) begin
         s4_mx_ff   <= MAG_W'(1) << tlqe_pkg::NORM_MSB;
         s4_my_ff   <= '0;
         s4_s_ff    <= SQ_W'(1) << (2*tlqe_pkg::NORM_MSB);
      end else begin
         s4_mx_ff   <= s3_mx_ff << s3_k_ff;
         s4_my_ff   <= s3_my_ff << s3_k_ff;
         s4_s_ff    <= s3_s_ff << {s3_k_ff, 1'b0};
      end
   end

   // square root, one root bit per stage
   logic                  sq_v_ff    [SQRT_STEPS];
   tlqe_pkg::carry_type   sq_c_ff    [SQRT_STEPS];
   logic [THICK_W-1:0]    sq_t_ff    [SQRT_STEPS];
   logic [MAG_W-1:0]      sq_mx_ff   [SQRT_STEPS];
   logic [MAG_W-1:0]      sq_my_ff   [SQRT_STEPS];
   logic [SQ_W-1:0]       sq_s_ff    [SQRT_STEPS];
   logic [REM_W-1:0]      sq_rem_ff  [SQRT_STEPS];
   logic [ROOT_W-1:0]     sq_root_ff [SQRT_STEPS];

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
      logic                v_in;
      tlqe_pkg::carry_type c_in;
      logic [THICK_W-1:0]  t_in;
      logic [MAG_W-1:0]    mx_in, my_in;
      logic [SQ_W-1:0]     s_in;
      logic [REM_W-1:0]    rem_in, r2, trial;
      logic [ROOT_W-1:0]   root_in;

      if (i == 0) begin : g_first
         assign v_in    = s4_v_ff;
         assign c_in    = s4_c_ff;
         assign t_in    = s4_t_ff;
         assign mx_in   = s4_mx_ff;
         assign my_in   = s4_my_ff;
         assign s_in    = s4_s_ff;
         assign rem_in  = '0;
         assign root_in = '0;
      end else begin : g_next
         assign v_in    = sq_v_ff[i-1];
         assign c_in    = sq_c_ff[i-1];
         assign t_in    = sq_t_ff[i-1];
         assign mx_in   = sq_mx_ff[i-1];
         assign my_in   = sq_my_ff[i-1];
         assign s_in    = sq_s_ff[i-1];
         assign rem_in  = sq_rem_ff[i-1];
         assign root_in = sq_root_ff[i-1];
      end

      assign r2    = {rem_in[REM_W-3:0], s_in[SQ_W-1 -: 2]};
      assign trial = REM_W'({root_in, 2'b01});

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[i] <= 1'b0;
         end else begin
            sq_v_ff[i] <= v_in;
         end
         sq_c_ff[i]  <= c_in;
         sq_t_ff[i]  <= t_in;
         sq_mx_ff[i] <= mx_in;
         sq_my_ff[i] <= my_in;
         sq_s_ff[i]  <= s_in << 2;
         if (r2 >= trial) begin
            sq_rem_ff[i]  <= r2 - trial;
            sq_root_ff[i] <= {root_in[ROOT_W-2:0], 1'b1};
         end else begin
            sq_rem_ff[i]  <= r2;
            sq_root_ff[i] <= {root_in[ROOT_W-2:0], 1'b0};
         end
      end
   end

   // stage 5: numerators and denominators, axis 0 is x, axis 1 is y
   logic                  s5_v_ff;
   tlqe_pkg::carry_type   s5_c_ff;
   logic [1:0][NUM_W-1:0] s5_num_ff;
   logic [1:0][DEN_W-1:0] s5_den_ff;
   logic [ROOT_W-1:0]     len;

   assign len = sq_root_ff[SQRT_STEPS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_v_ff <= 1'b0;
      end else begin
         s5_v_ff <= sq_v_ff[SQRT_STEPS-1];
      end
      s5_c_ff      <= sq_c_ff[SQRT_STEPS-1];
      s5_num_ff[0] <= NUM_W'(sq_my_ff[SQRT_STEPS-1]) * NUM_W'(sq_t_ff[SQRT_STEPS-1]);
      s5_num_ff[1] <= NUM_W'(sq_mx_ff[SQRT_STEPS-1]) * NUM_W'(sq_t_ff[SQRT_STEPS-1]);
      s5_den_ff[0] <= DEN_W'(w_eff) * DEN_W'(len);
      s5_den_ff[1] <= DEN_W'(h_eff) * DEN_W'(len);
   end

   // rounded division, one quotient bit per stage; top bit flags overflow
   logic                       dv_v_ff   [DIV_STEPS];
   tlqe_pkg::carry_type        dv_c_ff   [DIV_STEPS];
   logic [1:0][DIVR_W-1:0]     dv_rem_ff [DIV_STEPS];
   logic [1:0][DIVD_W-1:0]     dv_d_ff   [DIV_STEPS];
   logic [1:0][DIV_STEPS-1:0]  dv_q_ff   [DIV_STEPS];

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      localparam int BIT = DIV_STEPS - 1 - j;
      logic                      v_in;
      tlqe_pkg::carry_type       c_in;
      logic [1:0][DIVR_W-1:0]    rem_in;
      logic [1:0][DIVD_W-1:0]    d_in;
      logic [1:0][DIV_STEPS-1:0] q_in;
      logic [1:0][DIVC_W-1:0]    dsh;
      logic [1:0]                take;

      if (j == 0) begin : g_first
         assign v_in = s5_v_ff;
         assign c_in = s5_c_ff;
         assign q_in = '0;
         for (genvar a = 0; a < 2; a++) begin : g_axis
            assign rem_in[a] = DIVR_W'({s5_num_ff[a], 11'b0}) + DIVR_W'(s5_den_ff[a]);
            assign d_in[a]   = {s5_den_ff[a], 1'b0};
         end
      end else begin : g_next
         assign v_in   = dv_v_ff[j-1];
         assign c_in   = dv_c_ff[j-1];
         assign rem_in = dv_rem_ff[j-1];
         assign d_in   = dv_d_ff[j-1];
         assign q_in   = dv_q_ff[j-1];
      end

      for (genvar a = 0; a < 2; a++) begin : g_cmp
         assign dsh[a]  = DIVC_W'(d_in[a]) << BIT;
         assign take[a] = DIVC_W'(rem_in[a]) >= dsh[a];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[j] <= 1'b0;
         end else begin
            dv_v_ff[j] <= v_in;
         end
         dv_c_ff[j] <= c_in;
         dv_d_ff[j] <= d_in;
         for (int a = 0; a < 2; a++) begin
            if (take[a]) begin
               dv_rem_ff[j][a] <= rem_in[a] - dsh[a][DIVR_W-1:0];
               dv_q_ff[j][a]   <= q_in[a] | (DIV_STEPS'(1) << BIT);
            end else begin
               dv_rem_ff[j][a] <= rem_in[a];
               dv_q_ff[j][a]   <= q_in[a];
            end
         end
      end
   end

   // output stage: signed offsets, saturated corners
   logic                      rsp_strobe_ff;
   tlqe_pkg::rsp_type         rsp_ff;
   tlqe_pkg::rsp_type         rsp_in;
   tlqe_pkg::carry_type       fc;
   logic [1:0][OFF_W-2:0]     mag;
   logic signed [OFF_W-1:0]   ox, oy;

   assign fc = dv_c_ff[DIV_STEPS-1];

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         if (dv_q_ff[DIV_STEPS-1][a][DIV_STEPS-1]) begin
            mag[a] = (OFF_W-1)'(1) << (OFF_W-2);
         end else begin
            mag[a] = dv_q_ff[DIV_STEPS-1][a][OFF_W-2:0];
         end
      end
      ox = fc.ny ? OFF_W'(mag[0]) : -OFF_W'(mag[0]);
      oy = fc.nx ? -OFF_W'(mag[1]) : OFF_W'(mag[1]);
      rsp_in.corner0_x = sat_coord((COORD_W+3)'(fc.x0) + (COORD_W+3)'(ox));
      rsp_in.corner0_y = sat_coord((COORD_W+3)'(fc.y0) + (COORD_W+3)'(oy));
      rsp_in.corner1_x = sat_coord((COORD_W+3)'(fc.x0) - (COORD_W+3)'(ox));
      rsp_in.corner1_y = sat_coord((COORD_W+3)'(fc.y0) - (COORD_W+3)'(oy));
      rsp_in.corner2_x = sat_coord((COORD_W+3)'(fc.x1) + (COORD_W+3)'(ox));
      rsp_in.corner2_y = sat_coord((COORD_W+3)'(fc.y1) + (COORD_W+3)'(oy));
      rsp_in.corner3_x = sat_coord((COORD_W+3)'(fc.x1) - (COORD_W+3)'(ox));
      rsp_in.corner3_y = sat_coord((COORD_W+3)'(fc.y1) - (COORD_W+3)'(oy));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= dv_v_ff[DIV_STEPS-1];
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ===== design/tlqe_checker.sv =====
// Port-level checks for the thick line quad expander and their binding.
`default_nettype none

module tlqe_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           start,
   input wire logic                           busy,
   input wire tlqe_pkg::req_type              req_payload,
   input wire logic                           csr_write_en,
   input wire logic [tlqe_pkg::CSR_IDX_W-1:0] csr_index,
   input wire logic [tlqe_pkg::VIEW_W-1:0]    csr_wdata,
   input wire logic                           rsp_strobe,
   input wire tlqe_pkg::rsp_type              rsp_payload
);

   logic xfer;

   assign xfer = start & ~busy;

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      xfer |-> ##(tlqe_pkg::LATENCY) rsp_strobe)
      else $error("transfer without result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(xfer, tlqe_pkg::LATENCY))
      else $error("result without transfer");

   a_thin_line: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && $past(xfer && req_payload.thickness == '0, tlqe_pkg::LATENCY)
      |-> rsp_payload.corner0_x == $past(req_payload.start_x, tlqe_pkg::LATENCY)
       && rsp_payload.corner3_y == $past(req_payload.end_y, tlqe_pkg::LATENCY))
      else $error("zero thickness moved a corner");

   a_point: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && $past(xfer && req_payload.start_x == req_payload.end_x
                          && req_payload.start_y == req_payload.end_y, tlqe_pkg::LATENCY)
      |-> rsp_payload.corner0_x == rsp_payload.corner2_x
       && rsp_payload.corner1_y == rsp_payload.corner3_y)
      else $error("point segment corners differ");

endmodule

bind thick_line_quad_expand tlqe_checker u_tlqe_checker (.*);

`default_nettype wire
